// ===== rtl/core/jadd_pkg.sv =====
package jadd_pkg;

  localparam int CENTER_W   = 10;
  localparam int DEADZONE_W = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CENTER_W-1:0]   CENTER_RESET   = 10'd512;
  localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 9'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_DEADZONE = 2'd1
  } cfg_reg_t;

endpackage

// ===== rtl/core/jadd_if.sv =====
interface jadd_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic                   button_level;

  modport source (output valid, x_sample, y_sample, button_level, input ready);
  modport sink   (input valid, x_sample, y_sample, button_level, output ready);
endinterface

interface jadd_result_if;
  logic valid;
  logic ready;
  logic move_left;
  logic move_right;
  logic move_down;
  logic move_up;
  logic click;

  modport source (output valid, move_left, move_right, move_down, move_up, click,
                  input ready);
  modport sink   (input valid, move_left, move_right, move_down, move_up, click,
                  output ready);
endinterface

// ===== rtl/core/joystick_average_direction_decoder.sv =====
// Joystick direction decoder with a moving-average window and a deadzone.
// Input channel "sample": one transaction carries an X sample, a Y sample and
// the raw button pin level. Output channel "result": one transaction per input
// transaction, in order, with left/right/down/up flags and click.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 = center,
// 1 = deadzone); other indexes are dropped. Write only while the block is idle.
// Both windows share one synchronous memory of WINDOW_DEPTH entries: the entry
// at the write index is read into s1_old and overwritten in the accept cycle,
// and the running sums are updated from the old value when stage 1 moves on.
// Throughput: one transaction per cycle unless result.ready holds the stages.
// A result passes stage 1, the running-sum stage and the output register in order.
// Reset: center = 512, deadzone = 50, sums and write index cleared; per-entry
// valid bits make every window entry read as zero until it is written, so
// there is no clearing pass.
// Stall: the three stages hold and collapse bubbles; sample.ready drops only
// when the output register and both inner stages are full and result.ready
// is low.
module joystick_average_direction_decoder #(
  parameter int WINDOW_DEPTH = 32,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  jadd_sample_if.sink                    sample,
  jadd_result_if.source                  result,
  input  logic                           cfg_we,
  input  logic [jadd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jadd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W   = SAMPLE_BITS + IDX_W;
  localparam int THR_W   = 12 + IDX_W;
  localparam int CMP_W   = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int ENTRY_W = 2 * SAMPLE_BITS;

  logic [jadd_pkg::CENTER_W-1:0]   center;
  logic [jadd_pkg::DEADZONE_W-1:0] deadzone;

  logic [ENTRY_W-1:0]      mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] entry_valid;
  logic [IDX_W-1:0]        write_index;

  logic                   s1_valid;
  logic [ENTRY_W-1:0]     s1_old;
  logic                   s1_old_valid;
  logic [SAMPLE_BITS-1:0] s1_x;
  logic [SAMPLE_BITS-1:0] s1_y;
  logic                   s1_button;

  logic             s2_valid;
  logic [SUM_W-1:0] x_sum;
  logic [SUM_W-1:0] y_sum;
  logic             s2_button;

  logic out_valid;
  logic out_left, out_right, out_down, out_up, out_click;

  logic out_free, s2_free, s1_free;
  logic accept, s1_move, s2_move;

  logic [SAMPLE_BITS-1:0] old_x, old_y;
  logic [SUM_W-1:0]       x_sum_next, y_sum_next;

  logic [11:0]                   hi_base;
  logic [jadd_pkg::CENTER_W-1:0] lo_base;
  logic [THR_W-1:0]              hi_lim, lo_lim;
  logic                          lo_ok;
  logic [CMP_W-1:0]              x_cmp, y_cmp, hi_cmp, lo_cmp;

  assign out_free = !out_valid || result.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s2_move  = s2_valid && out_free;
  assign s1_move  = s1_valid && s2_free;

  assign sample.ready = s1_free;
  assign accept       = sample.valid && s1_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center   <= jadd_pkg::CENTER_RESET;
      deadzone <= jadd_pkg::DEADZONE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jadd_pkg::CFG_CENTER:   center   <= cfg_data[jadd_pkg::CENTER_W-1:0];
        jadd_pkg::CFG_DEADZONE: deadzone <= cfg_data[jadd_pkg::DEADZONE_W-1:0];
        default: ;
      endcase
    end
  end

  // window memory: read old entry and overwrite in the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old           <= mem[write_index];
      mem[write_index] <= {sample.x_sample, sample.y_sample};
      s1_x             <= sample.x_sample;
      s1_y             <= sample.y_sample;
      s1_button        <= sample.button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      write_index  <= '0;
      s1_valid     <= 1'b0;
      s1_old_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_old_valid             <= entry_valid[write_index];
        entry_valid[write_index] <= 1'b1;
        if (write_index == IDX_W'(WINDOW_DEPTH - 1)) begin
          write_index <= '0;
        end else begin
          write_index <= write_index + IDX_W'(1);
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign old_x = s1_old_valid ? s1_old[ENTRY_W-1:SAMPLE_BITS] : '0;
  assign old_y = s1_old_valid ? s1_old[SAMPLE_BITS-1:0] : '0;

  assign x_sum_next = x_sum - SUM_W'(old_x) + SUM_W'(s1_x);
  assign y_sum_next = y_sum - SUM_W'(old_y) + SUM_W'(s1_y);

  // running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      x_sum    <= '0;
      y_sum    <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        x_sum    <= x_sum_next;
        y_sum    <= y_sum_next;
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_button <= s1_button;
    end
  end

  // floor(sum/D) > center+dz  <=>  sum >= (center+dz+1)*D
  // floor(sum/D) < center-dz  <=>  sum <  (center-dz)*D
  assign hi_base = 12'(center) + 12'(deadzone) + 12'd1;
  assign lo_ok   = center > jadd_pkg::CENTER_W'(deadzone);
  assign lo_base = center - jadd_pkg::CENTER_W'(deadzone);
  assign hi_lim  = THR_W'(hi_base) * THR_W'(WINDOW_DEPTH);
  assign lo_lim  = THR_W'(lo_base) * THR_W'(WINDOW_DEPTH);

  assign x_cmp  = CMP_W'(x_sum);
  assign y_cmp  = CMP_W'(y_sum);
  assign hi_cmp = CMP_W'(hi_lim);
  assign lo_cmp = CMP_W'(lo_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_left  <= x_cmp >= hi_cmp;
      out_right <= lo_ok && (x_cmp < lo_cmp);
      out_down  <= y_cmp >= hi_cmp;
      out_up    <= lo_ok && (y_cmp < lo_cmp);
      out_click <= !s2_button;
    end
  end

  assign result.valid      = out_valid;
  assign result.move_left  = out_left;
  assign result.move_right = out_right;
  assign result.move_down  = out_down;
  assign result.move_up    = out_up;
  assign result.click      = out_click;

endmodule

// ===== rtl/core/jadd_chk.sv =====
module jadd_chk (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic move_left,
  input logic move_right,
  input logic move_down,
  input logic move_up,
  input logic click
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_x_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(move_left && move_right))
    else $error("left and right both set");

  a_y_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(move_down && move_up))
    else $error("down and up both set");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(move_left) && $stable(move_right)
      && $stable(move_down) && $stable(move_up) && $stable(click))
    else $error("result changed while stalled");

endmodule

bind joystick_average_direction_decoder jadd_chk u_jadd_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .move_left  (result.move_left),
  .move_right (result.move_right),
  .move_down  (result.move_down),
  .move_up    (result.move_up),
  .click      (result.click)
);
